>>> rtl/core/gea1_pkg.sv
// Shared constants, command type and filter function for the GEA-1 S register setup.
package gea1_pkg;

	localparam int unsigned SREG_W    = 64;
	localparam int unsigned KEY_W     = 64;
	localparam int unsigned IV_W      = 32;
	localparam int unsigned LOAD_W    = KEY_W + 1 + IV_W;
	localparam int unsigned BLANK_N   = 128;
	localparam int unsigned CLOCKS    = LOAD_W + BLANK_N;
	localparam int unsigned CNT_W     = $clog2(CLOCKS);
	localparam int unsigned S_TDATA_W = ((LOAD_W + 7) / 8) * 8;
	localparam int unsigned M_TDATA_W = ((SREG_W + 7) / 8) * 8;

	localparam int unsigned DIR_POS   = KEY_W;
	localparam int unsigned IV_LSB    = KEY_W + 1;

	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CLOCKS - 1);

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} dp_cmd_t;

	localparam logic NL_TABLE [0:127] = '{
		1'b0,1'b0,1'b1,1'b1,1'b1,1'b0,1'b0,1'b1,1'b1,1'b0,1'b1,1'b1,1'b1,1'b0,1'b1,1'b1,
		1'b0,1'b0,1'b1,1'b0,1'b1,1'b1,1'b0,1'b1,1'b1,1'b0,1'b1,1'b0,1'b1,1'b1,1'b1,1'b1,
		1'b1,1'b0,1'b1,1'b0,1'b1,1'b1,1'b0,1'b0,1'b0,1'b1,1'b1,1'b1,1'b1,1'b0,1'b1,1'b1,
		1'b0,1'b1,1'b0,1'b0,1'b0,1'b1,1'b1,1'b1,1'b1,1'b0,1'b0,1'b1,1'b0,1'b0,1'b0,1'b0,
		1'b0,1'b0,1'b0,1'b1,1'b0,1'b0,1'b1,1'b0,1'b1,1'b0,1'b0,1'b1,1'b0,1'b1,1'b0,1'b1,
		1'b0,1'b0,1'b1,1'b1,1'b0,1'b1,1'b0,1'b1,1'b1,1'b0,1'b0,1'b0,1'b0,1'b0,1'b0,1'b1,
		1'b0,1'b1,1'b1,1'b0,1'b0,1'b0,1'b0,1'b0,1'b1,1'b1,1'b0,1'b1,1'b0,1'b1,1'b0,1'b0,
		1'b1,1'b0,1'b1,1'b1,1'b1,1'b0,1'b0,1'b0,1'b0,1'b0,1'b1,1'b1,1'b1,1'b1,1'b1,1'b1
	};

	function automatic logic nl_bit(input logic [SREG_W-1:0] r);
		logic [6:0] idx;
		idx = {r[63], r[55], r[42], r[38], r[22], r[12], r[3]};
		return NL_TABLE[idx];
	endfunction

endpackage

>>> rtl/core/gea1_s_register_init.sv
// Top level: GEA-1 S register setup from key, direction and IV.
//
//   channel | dir | beat contents
//   s_*     | in  | tdata: key[63:0], direction[64], init_vector[96:65], zero pad
//   m_*     | out | tdata: seed_value[63:0]
//
// Each beat is loaded, the S register is clocked on the single feedback unit
// through the whole injection and blank run, and then S moves into the output register.
// A new beat is taken once the previous S has moved to the output register.
// A stalled output holds S there; a finished S waits in the core until free.
// arst_n clears the controller and result valid; no clearing pass is needed.
module gea1_s_register_init
	import gea1_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // key, direction, init_vector, pad
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // seed_value
);

	dp_cmd_t           dp_cmd;
	logic [SREG_W-1:0] seed;

	gea1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (dp_cmd)
	);

	gea1_dp u_dp (
		.clk       (clk),
		.cmd       (dp_cmd),
		.load_word (s_tdata[LOAD_W-1:0]),
		.result    (seed)
	);

	assign m_tdata = M_TDATA_W'(seed);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted beat did not start a run");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.publish |-> (!m_tvalid || m_tready))
		else $error("result overwritten before taken");

	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.publish |=> m_tvalid)
		else $error("published result not presented");

	a_no_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dp_cmd.step)
		else $error("register clocked while idle");

endmodule

>>> rtl/core/gea1_dp.sv
// Datapath: injection shifter, nonlinear S register and result register.
module gea1_dp
	import gea1_pkg::*;
(
	input  logic                clk,
	input  dp_cmd_t             cmd,
	input  logic [LOAD_W-1:0]   load_word,
	output logic [SREG_W-1:0]   result
);

	logic [LOAD_W-1:0] inj_q;
	logic [SREG_W-1:0] sreg_q;
	logic [SREG_W-1:0] out_q;
	logic              fb_bit;
	logic [LOAD_W-1:0] inj_order;

	// IV bits go in first, then direction, then key
	assign inj_order = {load_word[KEY_W-1:0], load_word[DIR_POS], load_word[LOAD_W-1:IV_LSB]};

	assign fb_bit = sreg_q[0] ^ nl_bit(sreg_q) ^ inj_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inj_q  <= inj_order;
			sreg_q <= '0;
		end else if (cmd.step) begin
			inj_q  <= {1'b0, inj_q[LOAD_W-1:1]};
			sreg_q <= {fb_bit, sreg_q[SREG_W-1:1]};
		end
		if (cmd.publish) begin
			out_q <= sreg_q;
		end
	end

	assign result = out_q;

endmodule

>>> rtl/core/gea1_ctrl.sv
// Controller: sequencing state machine, clock counter and result valid flag.
module gea1_ctrl
	import gea1_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.load    = in_ready && in_valid;
	assign cmd.step    = (state_q == ST_RUN);
	assign cmd.publish = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CNT) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
